### hdl/ascl_pkg.sv
// ----------------------------------------------------------------------------
// ascl_pkg
// Types, codes and constant words shared by the serial command link.
// ----------------------------------------------------------------------------
package ascl_pkg;

  localparam int WORD_W          = 32;
  localparam int IDX_W           = 8;
  localparam int STORE_WORDS_DEF = 256;

  typedef enum logic [1:0] {
    ACT_XFER = 2'd0,
    ACT_TICK = 2'd1,
    ACT_PULL = 2'd2
  } act_t;

  typedef enum logic [3:0] {
    PH_RESET     = 4'd0,
    PH_SHAKE     = 4'd1,
    PH_WAITCMD   = 4'd2,
    PH_WAITDAT   = 4'd3,
    PH_RESPDAT   = 4'd5,
    PH_RESPERR   = 4'd6,
    PH_WAITEVENT = 4'd8,
    PH_WAITRESP  = 4'd9
  } phase_t;

  localparam logic [7:0] CMD_SETUP    = 8'h17;
  localparam logic [7:0] CMD_VERSION  = 8'h12;
  localparam logic [7:0] CMD_STAT_A   = 8'h11;
  localparam logic [7:0] CMD_STAT_B   = 8'h13;
  localparam logic [7:0] CMD_CONN_ST  = 8'h20;
  localparam logic [7:0] CMD_REJ_A    = 8'h1A;
  localparam logic [7:0] CMD_REJ_B    = 8'h1B;
  localparam logic [7:0] CMD_REJ_C    = 8'h1F;
  localparam logic [7:0] CMD_REJ_D    = 8'h37;
  localparam logic [7:0] CMD_SEND     = 8'h24;
  localparam logic [7:0] CMD_SEND_W   = 8'h25;
  localparam logic [7:0] CMD_WAIT     = 8'h27;
  localparam logic [7:0] ERR_CODE_ONE = 8'h01;

  localparam logic [15:0] RESET_KEY   = 16'h494E;
  localparam logic [15:0] HDR_MARK    = 16'h9966;
  localparam logic [31:0] ERR_HDR     = 32'h996601EE;
  localparam logic [31:0] ACK_BASE    = 32'h99660080;
  localparam logic [31:0] WORD_BUSY   = 32'h80000000;
  localparam logic [31:0] VERSION_VAL = 32'h00830117;
  localparam logic [31:0] SHAKE_FIRST = 32'h494EB6B1;
  localparam logic [31:0] SHAKE_DONE  = 32'hB0BB8001;
  localparam logic [31:0] CONN_VAL    = 32'h01000000;
  localparam logic [31:0] NOTICE_HDR  = 32'h99660027;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              e0_set;
    logic [WORD_W-1:0] e0_val;
  } store_req_t;

  typedef struct packed {
    logic              res;
    logic              mem;
    logic [WORD_W-1:0] reply;
    logic              set17;
  } beat_res_t;

  function automatic logic [WORD_W:0] shake_lookup(input logic [WORD_W-1:0] w);
    logic [WORD_W:0] r;
    r = '0;
    case (w)
      32'hFFFF494E: r = {1'b1, 32'h494EB6B1};
      32'hB6B1494E: r = {1'b1, 32'h544EB6B1};
      32'hB6B1544E: r = {1'b1, 32'h544EABB1};
      32'hABB1544E: r = {1'b1, 32'h4E45ABB1};
      32'hABB14E45: r = {1'b1, 32'h4E45B1BA};
      32'hB1BA4E45: r = {1'b1, 32'h4F44B1BA};
      32'hB1BA4F44: r = {1'b1, 32'h4F44B0BB};
      32'hB0BB4F44: r = {1'b1, 32'h8001B0BB};
      default:      r = '0;
    endcase
    return r;
  endfunction

endpackage

### hdl/adapter_serial_command_link.sv
// ----------------------------------------------------------------------------
// adapter_serial_command_link
// Console-side serial command link of a wireless link adapter.
// ----------------------------------------------------------------------------
// Takes one beat per clock as long as results are drained: a host transfer,
// a frame tick or an adapter pull. Each beat is decoded against the link
// registers in the cycle it is accepted and issues a read of the word store
// and at most one write; a reply passes through the second-stage register
// and then the output register. The store read is registered, so the reply
// waits in the second stage for its data; a full output register that is
// not taken stalls the input once a further beat with a reply waits behind it.
module adapter_serial_command_link
  import ascl_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  logic [WORD_W-1:0] word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] reply_word
);

  logic              accept;
  store_req_t        req;
  beat_res_t         res;
  logic [WORD_W-1:0] mem_word;

  logic              s2_valid;
  logic              s2_res;
  logic              s2_mem;
  logic [WORD_W-1:0] s2_const;
  logic              set17_q;
  logic              s2_move;

  assign s2_move  = s2_valid && (!s2_res || !out_valid || out_ready);
  assign in_ready = !s2_valid || s2_move;
  assign accept   = in_valid && in_ready;

  ascl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .action   (action),
    .word     (word),
    .upd_en   (set17_q),
    .upd_byte (mem_word[7:0]),
    .req      (req),
    .res      (res)
  );

  ascl_store #(
    .STORE_WORDS (STORE_WORDS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .mem_word (mem_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s2_res    <= 1'b0;
      set17_q   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      set17_q <= accept && res.set17;
      if (accept) begin
        s2_valid <= 1'b1;
        s2_res   <= res.res;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move && s2_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_mem   <= res.mem;
      s2_const <= res.reply;
    end
    if (s2_move && s2_res) begin
      reply_word <= s2_mem ? mem_word : s2_const;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s2_valid && s2_res && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_xfer_result: assert property (@(posedge clk) disable iff (rst)
    accept && action == ACT_XFER |=> s2_valid && s2_res)
    else $error("host transfer produced no result");

  a_setup_timing: assert property (@(posedge clk) disable iff (rst)
    set17_q |-> $past(accept) && s2_valid)
    else $error("timeout update without a preceding beat");

endmodule

### hdl/ascl_store.sv
// ----------------------------------------------------------------------------
// ascl_store
// Word store with one write and one read port, registered read data, and a
// bypass for entry zero constants and same-cycle writes.
// ----------------------------------------------------------------------------
module ascl_store
  import ascl_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  store_req_t        req,
  output logic [WORD_W-1:0] mem_word
);

  localparam int AW = $clog2(STORE_WORDS);

  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic [WORD_W-1:0] rdata;
  logic              ovr_valid;
  logic [WORD_W-1:0] ovr_val;
  logic              ovr_valid_next;
  logic [WORD_W-1:0] ovr_val_next;
  logic              byp_valid;
  logic [WORD_W-1:0] byp_val;

  always_comb begin
    ovr_valid_next = ovr_valid;
    ovr_val_next   = ovr_val;
    if (req.e0_set) begin
      ovr_valid_next = 1'b1;
      ovr_val_next   = req.e0_val;
    end else if (req.wr_en && req.wr_addr[AW-1:0] == '0) begin
      ovr_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovr_valid <= 1'b0;
      byp_valid <= 1'b0;
    end else begin
      ovr_valid <= ovr_valid_next;
      if (req.rd_en) begin
        if (req.rd_addr[AW-1:0] == '0 && ovr_valid_next) begin
          byp_valid <= 1'b1;
          byp_val   <= ovr_val_next;
        end else if (req.wr_en && req.wr_addr[AW-1:0] == req.rd_addr[AW-1:0]) begin
          byp_valid <= 1'b1;
          byp_val   <= req.wr_data;
        end else begin
          byp_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ovr_val <= ovr_val_next;
  end

  assign mem_word = byp_valid ? byp_val : rdata;

endmodule

### hdl/ascl_ctrl.sv
// ----------------------------------------------------------------------------
// ascl_ctrl
// Link phase, command and index registers; decodes each beat into a store
// access and, where the beat has one, a reply.
// ----------------------------------------------------------------------------
module ascl_ctrl
  import ascl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        action,
  input  logic [WORD_W-1:0] word,
  input  logic              upd_en,
  input  logic [7:0]        upd_byte,
  output store_req_t        req,
  output beat_res_t         res
);

  phase_t           phase, phase_next;
  logic [7:0]       command_code, command_code_next;
  logic [7:0]       payload_length, payload_length_next;
  logic [IDX_W-1:0] word_index, word_index_next;
  logic [7:0]       timeout_setting;
  logic [7:0]       frames_left, frames_left_next;
  logic             pull_pending, pull_pending_next;

  logic [7:0]       timeout_eff;
  logic [IDX_W-1:0] idx_plus;
  logic [WORD_W:0]  shake_hit;

  logic [7:0]        fin_cmd;
  logic [7:0]        fin_len;
  logic              fin_err;
  logic              fin_ret;
  logic              fin_e0;
  logic [WORD_W-1:0] fin_e0_val;
  logic              fin_set17;
  logic              fin_wait;

  logic              do_finish;
  logic              do_deliver;
  logic [IDX_W-1:0]  dlv_plus;

  assign timeout_eff = upd_en ? upd_byte : timeout_setting;
  assign idx_plus    = word_index + IDX_W'(1);
  assign shake_hit   = shake_lookup(word);

  always_comb begin
    fin_cmd    = (phase == PH_WAITCMD) ? word[7:0] : command_code;
    fin_len    = (phase == PH_WAITCMD) ? 8'd0 : payload_length;
    fin_err    = 1'b0;
    fin_ret    = 1'b0;
    fin_e0     = 1'b0;
    fin_e0_val = '0;
    fin_set17  = 1'b0;
    case (fin_cmd)
      CMD_SETUP:   fin_set17 = 1'b1;
      CMD_VERSION: begin
        fin_ret    = 1'b1;
        fin_e0     = 1'b1;
        fin_e0_val = VERSION_VAL;
      end
      CMD_STAT_A, CMD_STAT_B: begin
        fin_ret    = 1'b1;
        fin_e0     = 1'b1;
      end
      CMD_CONN_ST: begin
        fin_ret    = 1'b1;
        fin_e0     = 1'b1;
        fin_e0_val = CONN_VAL;
      end
      CMD_REJ_A, CMD_REJ_B, CMD_REJ_C, CMD_REJ_D: fin_err = 1'b1;
      CMD_SEND, CMD_SEND_W: fin_err = (fin_len != 8'd0);
      default: ;
    endcase
    fin_wait = (fin_cmd == CMD_WAIT) || (fin_cmd == CMD_REJ_D) || (fin_cmd == CMD_SEND_W);
  end

  always_comb begin
    phase_next          = phase;
    command_code_next   = command_code;
    payload_length_next = payload_length;
    word_index_next     = word_index;
    frames_left_next    = frames_left;
    pull_pending_next   = pull_pending;
    req                 = '0;
    req.rd_en           = accept;
    res                 = '0;
    do_finish           = 1'b0;
    do_deliver          = 1'b0;
    dlv_plus            = '0;
    if (accept) begin
      case (action)
        ACT_XFER: begin
          res.res = 1'b1;
          case (phase)
            PH_RESET: begin
              if (word[15:0] == RESET_KEY) begin
                phase_next = PH_SHAKE;
                res.reply  = SHAKE_FIRST;
              end
            end
            PH_SHAKE: begin
              if (word == SHAKE_DONE) begin
                phase_next = PH_WAITCMD;
                res.reply  = WORD_BUSY;
              end else if (shake_hit[WORD_W]) begin
                res.reply = shake_hit[WORD_W-1:0];
              end
            end
            PH_WAITCMD: begin
              res.reply = WORD_BUSY;
              if (word[31:16] == HDR_MARK) begin
                payload_length_next = word[15:8];
                command_code_next   = word[7:0];
                word_index_next     = '0;
                if (word[15:8] != 8'd0) begin
                  phase_next = PH_WAITDAT;
                end else begin
                  do_finish = 1'b1;
                end
              end
            end
            PH_WAITDAT: begin
              req.wr_en       = 1'b1;
              req.wr_addr     = word_index;
              req.wr_data     = word;
              word_index_next = idx_plus;
              res.reply       = WORD_BUSY;
              if (idx_plus == payload_length) begin
                do_finish = 1'b1;
              end
            end
            PH_RESPERR: begin
              phase_next = PH_WAITCMD;
              res.reply  = {24'd0, command_code};
            end
            PH_RESPDAT: begin
              req.rd_addr     = word_index;
              res.mem         = 1'b1;
              word_index_next = idx_plus;
              if (idx_plus == payload_length) begin
                phase_next = PH_WAITCMD;
              end
            end
            default: ;
          endcase
        end
        ACT_TICK: begin
          if (phase != PH_RESET) begin
            do_deliver = 1'b1;
            if (phase == PH_WAITEVENT && frames_left != 8'd0) begin
              frames_left_next = frames_left - 8'd1;
              if (frames_left == 8'd1) begin
                req.e0_set          = 1'b1;
                req.e0_val          = NOTICE_HDR;
                req.wr_en           = 1'b1;
                req.wr_addr         = IDX_W'(1);
                req.wr_data         = WORD_BUSY;
                word_index_next     = '0;
                payload_length_next = 8'd2;
                phase_next          = PH_WAITRESP;
              end
            end
          end
        end
        ACT_PULL: begin
          if (phase == PH_WAITEVENT || phase == PH_WAITRESP) begin
            pull_pending_next = 1'b1;
            do_deliver        = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (do_finish) begin
      word_index_next = '0;
      req.e0_set      = fin_e0;
      req.e0_val      = fin_e0_val;
      req.rd_addr     = '0;
      res.set17       = fin_set17;
      if (fin_err) begin
        phase_next        = PH_RESPERR;
        command_code_next = ERR_CODE_ONE;
        res.reply         = ERR_HDR;
      end else begin
        payload_length_next = {7'd0, fin_ret};
        res.reply           = ACK_BASE | {23'd0, fin_ret, fin_cmd};
        if (fin_wait) begin
          phase_next       = PH_WAITEVENT;
          frames_left_next = timeout_eff;
        end else if (fin_ret) begin
          phase_next = PH_RESPDAT;
        end else begin
          phase_next = PH_WAITCMD;
        end
      end
    end

    if (do_deliver && phase_next == PH_WAITRESP && pull_pending_next) begin
      pull_pending_next = 1'b0;
      req.rd_addr       = word_index_next;
      res.res           = 1'b1;
      res.mem           = 1'b1;
      dlv_plus          = word_index_next + IDX_W'(1);
      word_index_next   = dlv_plus;
      if (dlv_plus == payload_length_next) begin
        phase_next = PH_WAITCMD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_RESET;
      command_code    <= '0;
      payload_length  <= '0;
      word_index      <= '0;
      timeout_setting <= '0;
      frames_left     <= '0;
      pull_pending    <= 1'b0;
    end else begin
      phase           <= phase_next;
      command_code    <= command_code_next;
      payload_length  <= payload_length_next;
      word_index      <= word_index_next;
      timeout_setting <= timeout_eff;
      frames_left     <= frames_left_next;
      pull_pending    <= pull_pending_next;
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the console-side serial command link.
// ----------------------------------------------------------------------------
// Walks the link out of reset through the handshake with a short table of
// beats, then drives random command traffic: headers, payloads, reply reads,
// error codes, wait commands timed out by frame ticks and the queued notice
// pulled word by word. An in-bench copy of the link state predicts the
// reply words, and table rows may give a reply outright. Both sides stall in
// random bursts, and the result side holds off once for a long stretch. The
// run closes by leaving the link stuck in a wait with zero timeout.
// ----------------------------------------------------------------------------
module tb;
  import ascl_pkg::*;

  typedef struct packed {
    act_t        a;
    logic [31:0] w;
    bit          lit;
    logic [31:0] r;
  } row_t;

  localparam int OPEN_ROWS = 26;
  localparam int PLAN_ROWS = 33;

  // {host word, reply} per handshake step, step 0 rightmost
  localparam logic [7:0][63:0] HS_STEPS = {
    64'hB0BB4F44_8001B0BB, 64'hB1BA4F44_4F44B0BB,
    64'hB1BA4E45_4F44B1BA, 64'hABB14E45_4E45B1BA,
    64'hABB1544E_4E45ABB1, 64'hB6B1544E_544EABB1,
    64'hB6B1494E_544EB6B1, 64'hFFFF494E_494EB6B1
  };

  localparam logic [11:0][7:0] CMD_POOL = {
    CMD_SETUP, CMD_VERSION, CMD_STAT_A, CMD_STAT_B, CMD_CONN_ST, CMD_REJ_A,
    CMD_REJ_B, CMD_REJ_C, CMD_REJ_D, CMD_SEND, CMD_SEND_W, CMD_WAIT
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [31:0] word;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] reply_word;

  // predicted link state
  phase_t      ph;
  logic [7:0]  op;
  logic [7:0]  span;
  logic [7:0]  pos;
  logic [31:0] words [0:255];
  logic [7:0]  wait_len;
  logic [7:0]  retry_cnt;
  logic [7:0]  frames_to_go;
  bit          pull_req;
  bit          head_known;

  logic [31:0] replies_due [$];
  logic [31:0] due;
  int          n_items;
  int          n_replies;
  int          n_cmds;
  int          n_notices;
  int          n_fail;
  bit          calm;
  bit          long_done;
  bit          backlog_done;

  adapter_serial_command_link dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .word       (word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reply_word (reply_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] close_command();
    int cnt;
    cnt = 0;
    pos = 8'd0;
    n_cmds++;
    case (op)
      CMD_SETUP: begin
        wait_len  = words[0][7:0];
        retry_cnt = words[0][15:8];
      end
      CMD_VERSION: begin
        words[0] = VERSION_VAL;
        head_known = 1'b1;
        cnt = 1;
      end
      CMD_STAT_A, CMD_STAT_B: begin
        words[0] = '0;
        head_known = 1'b1;
        cnt = 1;
      end
      CMD_CONN_ST: begin
        words[0] = CONN_VAL;
        head_known = 1'b1;
        cnt = 1;
      end
      CMD_REJ_A, CMD_REJ_B, CMD_REJ_C, CMD_REJ_D: cnt = -1;
      CMD_SEND, CMD_SEND_W: if (span != 8'd0) cnt = -1;
      default: ;
    endcase
    if (cnt < 0) begin
      ph = PH_RESPERR;
      op = ERR_CODE_ONE;
      return ERR_HDR;
    end
    span = cnt[7:0];
    if (op == CMD_WAIT || op == CMD_REJ_D || op == CMD_SEND_W) begin
      ph = PH_WAITEVENT;
      frames_to_go = wait_len;
    end else begin
      ph = (span != 8'd0) ? PH_RESPDAT : PH_WAITCMD;
    end
    return ACK_BASE | {24'h0, op} | {16'h0, span, 8'h0};
  endfunction

  function automatic logic [31:0] host_word(input logic [31:0] w);
    logic [31:0] r;
    r = '0;
    case (ph)
      PH_RESET: begin
        if (w[15:0] == RESET_KEY) begin
          ph = PH_SHAKE;
          r = SHAKE_FIRST;
        end
      end
      PH_SHAKE: begin
        if (w == SHAKE_DONE) begin
          ph = PH_WAITCMD;
          r = WORD_BUSY;
        end else begin
          for (int i = 0; i < 8; i++)
            if (w == HS_STEPS[i][63:32]) r = HS_STEPS[i][31:0];
        end
      end
      PH_WAITCMD: begin
        if (w[31:16] == HDR_MARK) begin
          span = w[15:8];
          op = w[7:0];
          pos = 8'd0;
          if (span != 8'd0) begin
            ph = PH_WAITDAT;
            r = WORD_BUSY;
          end else begin
            r = close_command();
          end
        end else begin
          r = WORD_BUSY;
        end
      end
      PH_WAITDAT: begin
        words[pos] = w;
        if (pos == 8'd0) head_known = 1'b1;
        pos = pos + 8'd1;
        r = (pos == span) ? close_command() : WORD_BUSY;
      end
      PH_RESPERR: begin
        ph = PH_WAITCMD;
        r = {24'h0, op};
      end
      PH_RESPDAT: begin
        r = words[pos];
        pos = pos + 8'd1;
        if (pos == span) ph = PH_WAITCMD;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit pop_notice(output logic [31:0] r);
    r = '0;
    if (ph != PH_WAITRESP || !pull_req) return 1'b0;
    pull_req = 1'b0;
    r = words[pos];
    pos = pos + 8'd1;
    if (pos == span) ph = PH_WAITCMD;
    return 1'b1;
  endfunction

  task automatic advance_link(input act_t a, input logic [31:0] w,
                              output bit got, output logic [31:0] r);
    got = 1'b0;
    r = '0;
    case (a)
      ACT_XFER: begin
        got = 1'b1;
        r = host_word(w);
      end
      ACT_TICK: begin
        if (ph != PH_RESET) begin
          if (ph == PH_WAITEVENT && frames_to_go != 8'd0) begin
            frames_to_go = frames_to_go - 8'd1;
            if (frames_to_go == 8'd0) begin
              words[0] = NOTICE_HDR;
              words[1] = WORD_BUSY;
              head_known = 1'b1;
              pos = 8'd0;
              span = 8'd2;
              ph = PH_WAITRESP;
              n_notices++;
            end
          end
          got = pop_notice(r);
        end
      end
      ACT_PULL: begin
        if (ph == PH_WAITEVENT || ph == PH_WAITRESP) begin
          pull_req = 1'b1;
          got = pop_notice(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic pick_beat(input bit settle, output act_t a, output logic [31:0] w);
    int roll;
    int k;
    logic [7:0] c;
    logic [7:0] n;
    roll = $urandom_range(99);
    a = ACT_XFER;
    w = $urandom;
    case (ph)
      PH_WAITCMD: begin
        if (roll < 8) begin
          a = roll[0] ? ACT_TICK : ACT_PULL;
        end else if (roll < 90) begin
          k = $urandom_range(15);
          c = (k < 12) ? CMD_POOL[k] : 8'($urandom);
          k = $urandom_range(99);
          if (k < 50) n = 8'd0;
          else if (k < 85) n = 8'($urandom_range(1, 3));
          else n = 8'($urandom_range(4, 8));
          if (!long_done && n_items > 250) begin
            n = 8'hFF;
            long_done = 1'b1;
          end
          // keep every timeout short enough to expire
          if (c == CMD_SETUP && n == 8'd0 &&
              (!head_known || words[0][7:0] == 8'd0 || words[0][7:0] > 8'd8))
            n = 8'd1;
          if ((c == CMD_WAIT || (c == CMD_SEND_W && n == 8'd0)) && wait_len == 8'd0)
            c = CMD_VERSION;
          w = {HDR_MARK, n, c};
        end else if (w[31:16] == HDR_MARK) begin
          w[31:16] = ~HDR_MARK;
        end
      end
      PH_WAITDAT: begin
        if (!settle && roll < 5) a = roll[0] ? ACT_TICK : ACT_PULL;
        else if (op == CMD_SETUP && pos == 8'd0)
          w[7:0] = ($urandom_range(4) == 0) ? 8'hFF : 8'($urandom_range(1, 5));
      end
      PH_RESPDAT, PH_RESPERR: begin
        if (!settle && roll < 5) a = roll[0] ? ACT_TICK : ACT_PULL;
      end
      PH_WAITEVENT: begin
        if (settle || roll < 65) a = ACT_TICK;
        else if (roll < 85) a = ACT_PULL;
      end
      PH_WAITRESP: begin
        if (settle || roll < 45) a = ACT_PULL;
        else if (roll < 80) a = ACT_TICK;
      end
      default: ;
    endcase
  endtask

  task automatic put_beat(input act_t a, input logic [31:0] w,
                          input bit lit, input logic [31:0] lit_r);
    bit got;
    logic [31:0] r;
    @(negedge clk);
    in_valid <= 1'b1;
    action <= a;
    word <= w;
    do @(posedge clk); while (!in_ready);
    if (a == ACT_XFER || ph == PH_WAITEVENT || ph == PH_WAITRESP) n_items++;
    if (n_items >= 560) calm = 1'b1;
    advance_link(a, w, got, r);
    if (got) replies_due.push_back(lit ? lit_r : r);
    if (!calm && (n_items / 40) % 3 != 2 && $urandom_range(3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(5)) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_replies++;
      if (replies_due.size() == 0) begin
        $error("reply_word: expected none, actual %h", reply_word);
        n_fail++;
      end else begin
        due = replies_due.pop_front();
        if (reply_word !== due) begin
          $error("reply_word: expected %h, actual %h", due, reply_word);
          n_fail++;
        end
      end
    end
  end

  initial begin : drain_side
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      gap = 0;
      if (!calm && !backlog_done && n_replies >= 120) begin
        gap = 90;
        backlog_done = 1'b1;
      end else if (!calm && (n_replies / 50) % 3 != 1 && $urandom_range(3) == 0) begin
        gap = $urandom_range(1, 6);
      end
      if (gap == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  initial begin : feed_side
    row_t plan [0:PLAN_ROWS-1];
    act_t a;
    logic [31:0] w;

    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_XFER;
    word = '0;
    ph = PH_RESET;
    op = '0;
    span = '0;
    pos = '0;
    wait_len = '0;
    retry_cnt = 8'd4;
    frames_to_go = '0;
    pull_req = 1'b0;
    head_known = 1'b0;
    n_items = 0;
    n_replies = 0;
    n_cmds = 0;
    n_notices = 0;
    n_fail = 0;
    calm = 1'b0;
    long_done = 1'b0;
    backlog_done = 1'b0;

    plan[0]  = {ACT_XFER, 32'h12345678, 1'b1, 32'h0};
    plan[1]  = {ACT_TICK, 32'h0, 1'b0, 32'h0};
    plan[2]  = {ACT_PULL, 32'h0, 1'b0, 32'h0};
    plan[3]  = {ACT_XFER, 32'hFFFF494E, 1'b1, SHAKE_FIRST};
    plan[4]  = {ACT_XFER, 32'hDEADBEEF, 1'b1, 32'h0};
    plan[5]  = {ACT_XFER, 32'hB6B1494E, 1'b0, 32'h0};
    plan[6]  = {ACT_XFER, 32'hB0BB4F44, 1'b0, 32'h0};
    plan[7]  = {ACT_XFER, SHAKE_DONE, 1'b1, WORD_BUSY};
    plan[8]  = {ACT_XFER, 32'h0, 1'b1, WORD_BUSY};
    plan[9]  = {ACT_XFER, {HDR_MARK, 8'h01, CMD_VERSION}, 1'b1, WORD_BUSY};
    plan[10] = {ACT_XFER, 32'hFFFFFFFF, 1'b0, 32'h0};
    plan[11] = {ACT_XFER, 32'h0, 1'b0, 32'h0};
    plan[12] = {ACT_XFER, {HDR_MARK, 8'h00, CMD_REJ_A}, 1'b1, ERR_HDR};
    plan[13] = {ACT_XFER, 32'hFFFFFFFF, 1'b1, {24'h0, ERR_CODE_ONE}};
    plan[14] = {ACT_XFER, {HDR_MARK, 8'h01, CMD_SETUP}, 1'b1, WORD_BUSY};
    plan[15] = {ACT_XFER, 32'h00000203, 1'b0, 32'h0};
    plan[16] = {ACT_PULL, 32'h0, 1'b0, 32'h0};
    plan[17] = {ACT_XFER, {HDR_MARK, 8'h00, CMD_WAIT}, 1'b0, 32'h0};
    plan[18] = {ACT_XFER, 32'hFFFFFFFF, 1'b1, 32'h0};
    plan[19] = {ACT_PULL, 32'h0, 1'b0, 32'h0};
    plan[20] = {ACT_TICK, 32'h0, 1'b0, 32'h0};
    plan[21] = {ACT_TICK, 32'h0, 1'b0, 32'h0};
    plan[22] = {ACT_TICK, 32'h0, 1'b0, 32'h0};
    plan[23] = {ACT_XFER, 32'h5555AAAA, 1'b1, 32'h0};
    plan[24] = {ACT_PULL, 32'h0, 1'b0, 32'h0};
    plan[25] = {ACT_XFER, {HDR_MARK, 8'h00, 8'hFF}, 1'b0, 32'h0};
    // closing: zero timeout leaves the link parked in the wait
    plan[26] = {ACT_XFER, {HDR_MARK, 8'h01, CMD_SETUP}, 1'b1, WORD_BUSY};
    plan[27] = {ACT_XFER, 32'h00000500, 1'b0, 32'h0};
    plan[28] = {ACT_XFER, {HDR_MARK, 8'h00, CMD_WAIT}, 1'b0, 32'h0};
    plan[29] = {ACT_TICK, 32'h0, 1'b0, 32'h0};
    plan[30] = {ACT_PULL, 32'h0, 1'b0, 32'h0};
    plan[31] = {ACT_XFER, 32'hFFFFFFFF, 1'b1, 32'h0};
    plan[32] = {ACT_TICK, 32'h0, 1'b0, 32'h0};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < OPEN_ROWS; i++)
      put_beat(plan[i].a, plan[i].w, plan[i].lit, plan[i].r);
    while (n_items < 600) begin
      pick_beat(1'b0, a, w);
      put_beat(a, w, 1'b0, '0);
    end
    while (ph != PH_WAITCMD) begin
      pick_beat(1'b1, a, w);
      put_beat(a, w, 1'b0, '0);
    end
    for (int i = OPEN_ROWS; i < PLAN_ROWS; i++)
      put_beat(plan[i].a, plan[i].w, plan[i].lit, plan[i].r);
    @(negedge clk);
    in_valid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("covered %0d beats, %0d replies, %0d commands, %0d wait timeouts",
             n_items, n_replies, n_cmds, n_notices);
    if (n_fail == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin : run_limit
    #2_000_000;
    $error("run limit reached, %0d replies outstanding", replies_due.size());
    $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
hdl/ascl_pkg.sv
hdl/ascl_store.sv
hdl/ascl_ctrl.sv
hdl/adapter_serial_command_link.sv
bench/tb.sv
